// File: rtl/vector_rotate_2d_assert.svh
// Assertion macros for the vector_rotate_2d block.
// Included by the top level; expects clk and arst_n in scope.
`ifndef VECTOR_ROTATE_2D_ASSERT_SVH
`define VECTOR_ROTATE_2D_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define VR2D_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("vector_rotate_2d assertion failed");

// Next-cycle implication, checked outside reset.
`define VR2D_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("vector_rotate_2d assertion failed");

`endif

// File: rtl/vr2d_pkg.sv
// Package for the vector_rotate_2d block: angle constants, arctangent table
// and the record handed from cell to cell. No dependencies.
`timescale 1ns / 1ps

package vr2d_pkg;

	localparam int unsigned MAX_STEPS = 32;

	// Angles in Q28 radians.
	localparam logic signed [33:0] ANG_PI      = 34'sd843314857;
	localparam logic signed [33:0] ANG_TWO_PI  = 34'sd1686629713;
	localparam logic signed [30:0] ANG_PI_N    = 31'sd843314857;
	localparam logic signed [30:0] ANG_HALF_PI = 31'sd421657428;

	// Thresholds for the wrap count: pi + k * two_pi.
	localparam logic signed [33:0] WRAP_T1 = 34'sd843314857;
	localparam logic signed [33:0] WRAP_T2 = 34'sd2529944570;
	localparam logic signed [33:0] WRAP_T3 = 34'sd4216574283;

	// CORDIC gain compensation in Q30.
	localparam logic signed [31:0] GAIN_Q30 = 32'sd652032874;

	// atan(2^-i) in Q28, rounded to nearest.
	localparam logic signed [30:0] ATAN_Q28 [MAX_STEPS] = '{
		31'sd210828714, 31'sd124459457, 31'sd65760959, 31'sd33381290,
		31'sd16755422,  31'sd8385879,   31'sd4193963,  31'sd2097109,
		31'sd1048571,   31'sd524287,    31'sd262144,   31'sd131072,
		31'sd65536,     31'sd32768,     31'sd16384,    31'sd8192,
		31'sd4096,      31'sd2048,      31'sd1024,     31'sd512,
		31'sd256,       31'sd128,       31'sd64,       31'sd32,
		31'sd16,        31'sd8,         31'sd4,        31'sd2,
		31'sd1,         31'sd0,         31'sd0,        31'sd0
	};

	// Rounding constant for the Q30 product sums.
	localparam logic signed [64:0] RND_Q30 = 65'sd536870912;

	typedef struct packed {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] cx;
		logic signed [31:0] sy;
		logic signed [30:0] z;
		logic               neg;
	} rot_t;

endpackage

// File: rtl/vr2d_prep.sv
// Angle preparation for vector_rotate_2d: wrap into [-pi, pi], quadrant fold,
// CORDIC start values. Three pipeline stages. Depends on vr2d_pkg.
`timescale 1ns / 1ps

module vr2d_prep (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic signed [31:0]   x_in,
	input  logic signed [31:0]   y_in,
	input  logic signed [20:0]   turn_angle,
	output logic                 out_valid,
	input  logic                 out_ready,
	output vr2d_pkg::rot_t       out_data
);

	logic v_s1, v_s2, v_s3;
	logic rdy1, rdy2, rdy3;

	logic signed [31:0] x_s1, y_s1, x_s2, y_s2;
	logic signed [33:0] z_s1, off_s1;
	logic signed [30:0] z_s2;
	vr2d_pkg::rot_t     d_s3;

	logic signed [33:0] z_wide, off_sel, z_sub;
	logic [1:0]         n_pos, n_neg;
	logic signed [30:0] z_fold;
	logic               neg_fold;

	assign rdy3     = !v_s3 || out_ready;
	assign rdy2     = !v_s2 || rdy3;
	assign rdy1     = !v_s1 || rdy2;
	assign in_ready = rdy1;

	// The angle in Q28 is the Q16 input shifted up by twelve bits.
	assign z_wide = {turn_angle[20], turn_angle, 12'b0};

	always_comb begin
		n_pos = 2'(z_wide > vr2d_pkg::WRAP_T1) + 2'(z_wide > vr2d_pkg::WRAP_T2)
			+ 2'(z_wide > vr2d_pkg::WRAP_T3);
		n_neg = 2'(z_wide < -vr2d_pkg::WRAP_T1) + 2'(z_wide < -vr2d_pkg::WRAP_T2)
			+ 2'(z_wide < -vr2d_pkg::WRAP_T3);
		case (n_pos)
			2'd1:    off_sel = vr2d_pkg::ANG_TWO_PI;
			2'd2:    off_sel = vr2d_pkg::ANG_TWO_PI + vr2d_pkg::ANG_TWO_PI;
			2'd3:    off_sel = vr2d_pkg::ANG_TWO_PI + vr2d_pkg::ANG_TWO_PI
				+ vr2d_pkg::ANG_TWO_PI;
			default: begin
				case (n_neg)
					2'd1:    off_sel = -vr2d_pkg::ANG_TWO_PI;
					2'd2:    off_sel = -(vr2d_pkg::ANG_TWO_PI + vr2d_pkg::ANG_TWO_PI);
					2'd3:    off_sel = -(vr2d_pkg::ANG_TWO_PI + vr2d_pkg::ANG_TWO_PI
						+ vr2d_pkg::ANG_TWO_PI);
					default: off_sel = '0;
				endcase
			end
		endcase
	end

	assign z_sub = z_s1 - off_s1;

	always_comb begin
		if (z_s2 > vr2d_pkg::ANG_HALF_PI) begin
			z_fold   = z_s2 - vr2d_pkg::ANG_PI_N;
			neg_fold = 1'b1;
		end else if (z_s2 < -vr2d_pkg::ANG_HALF_PI) begin
			z_fold   = z_s2 + vr2d_pkg::ANG_PI_N;
			neg_fold = 1'b1;
		end else begin
			z_fold   = z_s2;
			neg_fold = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= in_valid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1 && in_valid) begin
			x_s1   <= x_in;
			y_s1   <= y_in;
			z_s1   <= z_wide;
			off_s1 <= off_sel;
		end
		if (rdy2 && v_s1) begin
			x_s2 <= x_s1;
			y_s2 <= y_s1;
			z_s2 <= z_sub[30:0];
		end
		if (rdy3 && v_s2) begin
			d_s3.x   <= x_s2;
			d_s3.y   <= y_s2;
			d_s3.cx  <= vr2d_pkg::GAIN_Q30;
			d_s3.sy  <= '0;
			d_s3.z   <= z_fold;
			d_s3.neg <= neg_fold;
		end
	end

	assign out_valid = v_s3;
	assign out_data  = d_s3;

endmodule

// File: rtl/vr2d_cell.sv
// One CORDIC rotation step for vector_rotate_2d, with its own pipeline
// register and handshake. Depends on vr2d_pkg.
`timescale 1ns / 1ps

module vr2d_cell #(
	parameter int unsigned STEP = 0
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  vr2d_pkg::rot_t in_data,
	output logic           out_valid,
	input  logic           out_ready,
	output vr2d_pkg::rot_t out_data
);

	logic           v_q;
	vr2d_pkg::rot_t d_q, d_next;
	logic signed [31:0] dx, dy;

	assign in_ready = !v_q || out_ready;

	assign dx = in_data.sy >>> STEP;
	assign dy = in_data.cx >>> STEP;

	always_comb begin
		d_next = in_data;
		// Rotate toward zero residual angle.
		if (!in_data.z[30]) begin
			d_next.cx = in_data.cx - dx;
			d_next.sy = in_data.sy + dy;
			d_next.z  = in_data.z - vr2d_pkg::ATAN_Q28[STEP];
		end else begin
			d_next.cx = in_data.cx + dx;
			d_next.sy = in_data.sy - dy;
			d_next.z  = in_data.z + vr2d_pkg::ATAN_Q28[STEP];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (in_ready) begin
			v_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			d_q <= d_next;
		end
	end

	assign out_valid = v_q;
	assign out_data  = d_q;

endmodule

// File: rtl/vr2d_post.sv
// Back end of vector_rotate_2d: quadrant sign, four products, rounded sums
// and saturation into the output register. Depends on vr2d_pkg.
`timescale 1ns / 1ps

module vr2d_post (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  vr2d_pkg::rot_t     in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] x_out,
	output logic signed [31:0] y_out,
	output logic               clipped
);

	logic v_s1, v_s2, v_s3, v_s4;
	logic rdy1, rdy2, rdy3, rdy4;

	logic signed [31:0] x_s1, y_s1, cx_s1, sy_s1;
	logic signed [63:0] pxc_s2, pys_s2, pyc_s2, pxs_s2;
	logic signed [34:0] rx_s3, ry_s3;
	logic signed [31:0] x_s4, y_s4;
	logic               clip_s4;

	logic signed [64:0] acc_x, acc_y;
	logic               ovf_x, ovf_y;
	logic signed [31:0] sat_x, sat_y;

	assign rdy4     = !v_s4 || out_ready;
	assign rdy3     = !v_s3 || rdy4;
	assign rdy2     = !v_s2 || rdy3;
	assign rdy1     = !v_s1 || rdy2;
	assign in_ready = rdy1;

	assign acc_x = {pxc_s2[63], pxc_s2} + {pys_s2[63], pys_s2} + vr2d_pkg::RND_Q30;
	assign acc_y = {pyc_s2[63], pyc_s2} - {pxs_s2[63], pxs_s2} + vr2d_pkg::RND_Q30;

	// A value fits 32 bits when its top four bits all match the sign.
	assign ovf_x = (rx_s3[34:31] != {4{rx_s3[34]}});
	assign ovf_y = (ry_s3[34:31] != {4{ry_s3[34]}});
	assign sat_x = ovf_x ? {rx_s3[34], {31{!rx_s3[34]}}} : rx_s3[31:0];
	assign sat_y = ovf_y ? {ry_s3[34], {31{!ry_s3[34]}}} : ry_s3[31:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= in_valid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
			if (rdy4) v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1 && in_valid) begin
			x_s1  <= in_data.x;
			y_s1  <= in_data.y;
			cx_s1 <= in_data.neg ? -in_data.cx : in_data.cx;
			sy_s1 <= in_data.neg ? -in_data.sy : in_data.sy;
		end
		if (rdy2 && v_s1) begin
			pxc_s2 <= x_s1 * cx_s1;
			pys_s2 <= y_s1 * sy_s1;
			pyc_s2 <= y_s1 * cx_s1;
			pxs_s2 <= x_s1 * sy_s1;
		end
		if (rdy3 && v_s2) begin
			rx_s3 <= acc_x[64:30];
			ry_s3 <= acc_y[64:30];
		end
		if (rdy4 && v_s3) begin
			x_s4    <= sat_x;
			y_s4    <= sat_y;
			clip_s4 <= ovf_x || ovf_y;
		end
	end

	assign out_valid = v_s4;
	assign x_out     = x_s4;
	assign y_out     = y_s4;
	assign clipped   = clip_s4;

endmodule

// File: rtl/vector_rotate_2d.sv
// Top level of vector_rotate_2d: clockwise rotation of a Q15.16 vector by an
// angle, built from vr2d_prep, a row of vr2d_cell and vr2d_post (uses vr2d_pkg).
//
//   Channel  Direction  Transaction payload
//   s_axis   in         tdata: x_in[31:0], y_in[63:32], turn_angle[84:64], zero pad
//   m_axis   out        tdata: x_out[31:0], y_out[63:32]; tuser: clipped[0]
//
// One transaction is taken per clock cycle when the result side keeps up.
// A transaction passes through the angle wrap and fold stages, each CORDIC cell
// in turn, then the sign, product, rounded-sum and saturation stages.
// Every stage has its own valid bit and moves whenever its successor has room,
// so bubbles close up and the input keeps accepting while a result waits,
// until every stage holds a transaction.
// Reset clears only the valid bits; there is no clearing pass.
`timescale 1ns / 1ps
`include "vector_rotate_2d_assert.svh"

module vector_rotate_2d #(
	parameter int unsigned CORDIC_STEPS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// x_in [31:0], y_in [63:32], turn_angle [84:64], zero [87:85]
	input  logic [87:0] s_axis_tdata,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// x_out [31:0], y_out [63:32]
	output logic [63:0] m_axis_tdata,
	// clipped [0]
	output logic [0:0]  m_axis_tuser
);

	// The arctangent table holds 32 entries; more steps add nothing.
	localparam int unsigned NSTEP = (CORDIC_STEPS > vr2d_pkg::MAX_STEPS) ?
		vr2d_pkg::MAX_STEPS : CORDIC_STEPS;

	// chain index k is the input of cell k; the last entry feeds the back end.
	vr2d_pkg::rot_t chain_d [NSTEP+1];
	logic           chain_v [NSTEP+1];
	logic           chain_r [NSTEP+1];

	logic signed [31:0] x_res, y_res;
	logic               clip_res;

	// Angle wrap into [-pi, pi] and fold into [-pi/2, pi/2].
	vr2d_prep u_prep (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.x_in       (s_axis_tdata[31:0]),
		.y_in       (s_axis_tdata[63:32]),
		.turn_angle (s_axis_tdata[84:64]),
		.out_valid  (chain_v[0]),
		.out_ready  (chain_r[0]),
		.out_data   (chain_d[0])
	);

	// The CORDIC row: each cell performs one micro-rotation and hands its
	// cosine, sine and residual angle to the next cell.
	for (genvar k = 0; k < NSTEP; k++) begin : g_cell
		vr2d_cell #(
			.STEP (k)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (chain_v[k]),
			.in_ready  (chain_r[k]),
			.in_data   (chain_d[k]),
			.out_valid (chain_v[k+1]),
			.out_ready (chain_r[k+1]),
			.out_data  (chain_d[k+1])
		);
	end

	// Sign restore, products, rounding and saturation.
	vr2d_post u_post (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (chain_v[NSTEP]),
		.in_ready  (chain_r[NSTEP]),
		.in_data   (chain_d[NSTEP]),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.x_out     (x_res),
		.y_out     (y_res),
		.clipped   (clip_res)
	);

	assign m_axis_tdata = {y_res, x_res};
	assign m_axis_tuser = clip_res;

	// The folded angle entering the row never exceeds a quarter turn.
	`VR2D_ASSERT_IMP(a_fold_range, chain_v[0],
		(chain_d[0].z <= vr2d_pkg::ANG_HALF_PI) && (chain_d[0].z >= -vr2d_pkg::ANG_HALF_PI))

	// A clipped result carries a rail value in at least one component.
	`VR2D_ASSERT_IMP(a_clip_rail, m_axis_tvalid && m_axis_tuser[0],
		(m_axis_tdata[31:0] == 32'h7fffffff) || (m_axis_tdata[31:0] == 32'h80000000) ||
		(m_axis_tdata[63:32] == 32'h7fffffff) || (m_axis_tdata[63:32] == 32'h80000000))

	// With the output register empty every stage has room, so input is taken.
	`VR2D_ASSERT_IMP(a_empty_ready, !m_axis_tvalid, s_axis_tready)

	// A transaction stalled between the front end and the row stays put.
	`VR2D_ASSERT_NXT(a_prep_hold, chain_v[0] && !chain_r[0], chain_v[0])

endmodule
